>>> src/i2c_slave_byte_engine_top_assert.svh
// Assertion macros for the I2C slave byte engine.
// Used by the port checker; no other dependencies.
`ifndef I2C_SLAVE_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_SLAVE_BYTE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ise_pkg.sv
// Shared types and constants of the I2C slave byte engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package ise_pkg;

    localparam int RX_DEPTH_DEF = 16;
    localparam int TX_DEPTH_DEF = 16;

    localparam int MODE_W   = 3;
    localparam int ADDR7_W  = 7;
    localparam int COUNT_W  = 5;

    // Event codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_START    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TX_WRITE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RX_READ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        shifted_byte;
        logic [3:0]        host_index;
        logic [7:0]        host_value;
    } item_t;

    typedef struct packed {
        logic               sda_drive;
        logic [7:0]         load_byte;
        logic               shift_one_bit;
        logic               listening;
        logic [7:0]         read_data;
        logic               new_frame;
        logic               new_byte;
        logic [COUNT_W-1:0] received_count;
    } result_t;

endpackage

`default_nettype wire

>>> src/ise_store.sv
// Byte store: one-write, one-read synchronous memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses ise_pkg.
`default_nettype none

module ise_store
    import ise_pkg::*;
#(
    parameter int   DEPTH = RX_DEPTH_DEF,
    parameter int   WIDTH = 8,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> src/ise_seq.sv
// Transfer sequencer: phase, positions, flags and the result register.
// Reads the stores when an item is taken and updates state in the following cycle. Uses ise_pkg.
`default_nettype none

module ise_seq
    import ise_pkg::*;
#(
    parameter int   RX_DEPTH = RX_DEPTH_DEF,
    parameter int   TX_DEPTH = TX_DEPTH_DEF,
    localparam int  RAW      = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1,
    localparam int  TAW      = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
    localparam int  RPW      = $clog2(RX_DEPTH + 1),
    localparam int  TPW      = $clog2(TX_DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [ADDR7_W-1:0] cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire item_t              in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output result_t                 out_result,
    output logic                    tx_rd_en,
    output logic [TAW-1:0]          tx_rd_addr,
    input  wire logic [7:0]         tx_rd_data,
    output logic                    tx_wr_en,
    output logic [TAW-1:0]          tx_wr_addr,
    output logic [7:0]              tx_wr_data,
    output logic                    rx_rd_en,
    output logic [RAW-1:0]          rx_rd_addr,
    input  wire logic [7:0]         rx_rd_data,
    output logic                    rx_wr_en,
    output logic [RAW-1:0]          rx_wr_addr,
    output logic [7:0]              rx_wr_data
);

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_ADDR        = 3'd1;
    localparam logic [2:0] PH_SEND        = 3'd2;
    localparam logic [2:0] PH_WAIT_REPLY  = 3'd3;
    localparam logic [2:0] PH_CHECK_REPLY = 3'd4;
    localparam logic [2:0] PH_REQ_DATA    = 3'd5;
    localparam logic [2:0] PH_GET_DATA    = 3'd6;

    logic               exec_reg;
    item_t              item_reg;
    logic [2:0]         phase_reg, phase_next;
    logic [TPW-1:0]     tx_pos_reg, tx_pos_next;
    logic [RPW-1:0]     rx_pos_reg, rx_pos_next;
    logic               frame_reg, frame_next;
    logic               byte_reg, byte_next;
    logic [ADDR7_W-1:0] own_addr_reg;
    logic               out_valid_reg;
    result_t            result_reg, result_next;
    logic               accept;
    logic               tx_more;
    logic               rx_room;
    logic               host_tx_ok;
    logic               host_rx_ok;

    assign in_ready = !exec_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign tx_more    = 32'(tx_pos_reg) < TX_DEPTH;
    assign rx_room    = 32'(rx_pos_reg) < RX_DEPTH;
    assign host_tx_ok = 32'(item_reg.host_index) < TX_DEPTH;
    assign host_rx_ok = 32'(item_reg.host_index) < RX_DEPTH;

    // The stores are read when the item is taken; the data is ready in the execute cycle.
    assign tx_rd_en   = accept && tx_more;
    assign tx_rd_addr = TAW'(tx_pos_reg);
    assign rx_rd_en   = accept && (32'(in_item.host_index) < RX_DEPTH);
    assign rx_rd_addr = RAW'(in_item.host_index);

    assign tx_wr_addr = TAW'(item_reg.host_index);
    assign tx_wr_data = item_reg.host_value;
    assign rx_wr_addr = RAW'(rx_pos_reg);
    assign rx_wr_data = item_reg.shifted_byte;

    always_comb begin
        phase_next  = phase_reg;
        tx_pos_next = tx_pos_reg;
        rx_pos_next = rx_pos_reg;
        frame_next  = frame_reg;
        byte_next   = byte_reg;
        tx_wr_en    = 1'b0;
        rx_wr_en    = 1'b0;
        result_next = '0;
        result_next.listening = (phase_reg != PH_IDLE);

        case (item_reg.mode)
            MODE_START: begin
                phase_next = PH_ADDR;
                result_next.listening = 1'b1;
            end
            MODE_OVERFLOW: begin
                case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_ADDR: begin
                        if (item_reg.shifted_byte[7:1] == own_addr_reg) begin
                            if (item_reg.shifted_byte[0]) begin
                                phase_next  = PH_SEND;
                                tx_pos_next = '0;
                            end else begin
                                phase_next  = PH_REQ_DATA;
                                rx_pos_next = '0;
                            end
                            result_next.sda_drive     = 1'b1;
                            result_next.shift_one_bit = 1'b1;
                            result_next.listening     = 1'b1;
                        end else begin
                            phase_next = PH_IDLE;
                            result_next.listening = 1'b0;
                        end
                    end
                    PH_SEND, PH_CHECK_REPLY: begin
                        // A nonzero acknowledge bit is a NACK and ends the read transfer.
                        if ((phase_reg == PH_CHECK_REPLY && item_reg.shifted_byte != 8'd0)
                                || !tx_more) begin
                            phase_next = PH_IDLE;
                            result_next.listening = 1'b0;
                        end else begin
                            phase_next  = PH_WAIT_REPLY;
                            tx_pos_next = tx_pos_reg + 1'b1;
                            result_next.sda_drive = 1'b1;
                            result_next.load_byte = tx_rd_data;
                            result_next.listening = 1'b1;
                        end
                    end
                    PH_WAIT_REPLY: begin
                        phase_next = PH_CHECK_REPLY;
                        result_next.shift_one_bit = 1'b1;
                        result_next.listening     = 1'b1;
                    end
                    PH_REQ_DATA: begin
                        phase_next = PH_GET_DATA;
                        result_next.listening = 1'b1;
                    end
                    PH_GET_DATA: begin
                        // Bytes past the end of the receive store are acknowledged and dropped.
                        if (rx_room) begin
                            rx_wr_en    = exec_reg;
                            rx_pos_next = rx_pos_reg + 1'b1;
                            byte_next   = 1'b1;
                            if (rx_pos_reg == '0) begin
                                frame_next = 1'b1;
                            end
                        end
                        phase_next = PH_REQ_DATA;
                        result_next.sda_drive     = 1'b1;
                        result_next.shift_one_bit = 1'b1;
                        result_next.listening     = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        result_next.listening = 1'b0;
                    end
                endcase
            end
            MODE_TX_WRITE: begin
                tx_wr_en = exec_reg && host_tx_ok;
            end
            MODE_RX_READ: begin
                if (host_rx_ok) begin
                    result_next.read_data = rx_rd_data;
                end
            end
            MODE_CLEAR: begin
                frame_next = 1'b0;
                byte_next  = 1'b0;
            end
            default: begin
            end
        endcase

        result_next.new_frame      = frame_next;
        result_next.new_byte       = byte_next;
        result_next.received_count = COUNT_W'(rx_pos_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            tx_pos_reg    <= '0;
            rx_pos_reg    <= '0;
            frame_reg     <= 1'b0;
            byte_reg      <= 1'b0;
            own_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            exec_reg <= accept;
            if (cfg_wr_en) begin
                own_addr_reg <= cfg_wr_data;
            end
            if (exec_reg) begin
                phase_reg     <= phase_next;
                tx_pos_reg    <= tx_pos_next;
                rx_pos_reg    <= rx_pos_next;
                frame_reg     <= frame_next;
                byte_reg      <= byte_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (exec_reg) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

>>> src/i2c_slave_byte_engine_top.sv
// I2C slave byte engine, top level: stream ports, sequencer and the two byte stores.
// An input transfer is taken when s_tvalid and s_tready are both high; every input
// transfer gives exactly one result transfer. The transmit and receive stores are
// synchronous memories with registered read data, read when the item is taken; the
// sequencer applies the item in the following cycle and loads the result register.
// No new item is taken during that update cycle, so a store access never overlaps a
// write to the same entry; nor is one taken while a stalled result waits. Stores read
// as zero until written; no clearing pass runs after reset. own_address must be
// written by the user through cfg_wr_en and cfg_wr_data only while no transfer is
// in flight; the block itself does not enforce this. Depends on ise_pkg.
`default_nettype none

module i2c_slave_byte_engine_top
    import ise_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [ADDR7_W-1:0] cfg_wr_data,  // own_address
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [23:0]        s_tdata,      // shifted_byte, host_index, host_value, pad
    input  wire logic [2:0]         s_tuser,      // mode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // sda_drive, load_byte, shift_one_bit, listening, read_data, new_frame,
    // new_byte, received_count, pad
    output logic [31:0]             m_tdata
);

    localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    item_t          in_item;
    result_t        res;
    logic           tx_rd_en, tx_wr_en, rx_rd_en, rx_wr_en;
    logic [TAW-1:0] tx_rd_addr, tx_wr_addr;
    logic [RAW-1:0] rx_rd_addr, rx_wr_addr;
    logic [7:0]     tx_rd_data, tx_wr_data, rx_rd_data, rx_wr_data;

    assign in_item.mode         = s_tuser;
    assign in_item.shifted_byte = s_tdata[7:0];
    assign in_item.host_index   = s_tdata[11:8];
    assign in_item.host_value   = s_tdata[19:12];

    assign m_tdata = {6'd0, res.received_count, res.new_byte, res.new_frame,
                      res.read_data, res.listening, res.shift_one_bit,
                      res.load_byte, res.sda_drive};

    ise_seq #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (res),
        .tx_rd_en    (tx_rd_en),
        .tx_rd_addr  (tx_rd_addr),
        .tx_rd_data  (tx_rd_data),
        .tx_wr_en    (tx_wr_en),
        .tx_wr_addr  (tx_wr_addr),
        .tx_wr_data  (tx_wr_data),
        .rx_rd_en    (rx_rd_en),
        .rx_rd_addr  (rx_rd_addr),
        .rx_rd_data  (rx_rd_data),
        .rx_wr_en    (rx_wr_en),
        .rx_wr_addr  (rx_wr_addr),
        .rx_wr_data  (rx_wr_data)
    );

    ise_store #(
        .DEPTH (TX_DEPTH),
        .WIDTH (8)
    ) u_tx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    ise_store #(
        .DEPTH (RX_DEPTH),
        .WIDTH (8)
    ) u_rx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

endmodule

`default_nettype wire

>>> src/ise_checker.sv
// Port-level checker for the I2C slave byte engine, bound to the top level.
// Depends on the assertion macros in i2c_slave_byte_engine_top_assert.svh.
`default_nettype none
`include "i2c_slave_byte_engine_top_assert.svh"

module ise_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result must hold.
    `ISE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The block takes one item at a time: never two transfers on consecutive edges.
    `ISE_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken during update cycle")

    // Each accepted item yields a result once it has passed the execute register and the result register.
    `ISE_ASSERT_NXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, ##1 m_tvalid, "no result after accepted item")

    // An idle slave never drives SDA nor asks for an ack bit.
    `ISE_ASSERT_IMP(a_idle_quiet, aclk, aresetn, m_tvalid && !m_tdata[10], !m_tdata[0] && !m_tdata[9], "line active while not listening")

endmodule

bind i2c_slave_byte_engine_top ise_checker u_ise_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/i2c_slave_byte_engine_top_tb.sv
// Self-checking testbench for i2c_slave_byte_engine_top: directed events, random
// I2C frames under stream backpressure, and a long receiver stall.
// Depends on ise_pkg and the top level of the block.
`timescale 1ns / 100ps

module i2c_slave_byte_engine_top_tb;
    import ise_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Mode codes the block leaves undefined.
    localparam logic [MODE_W-1:0] MODE_UNDEF_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_7 = 3'd7;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ADDR,
        SEQ_TX_LOAD,
        SEQ_TX_SHIFT,
        SEQ_TX_ACK,
        SEQ_RX_ACK,
        SEQ_RX_DATA
    } seq_phase_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [ADDR7_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata = '0;   // shifted_byte, host_index, host_value, pad
    logic [2:0]         s_tuser = '0;   // mode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // sda_drive, load_byte, shift_one_bit, listening, read_data, new_frame,
    // new_byte, received_count, pad
    logic [31:0]        m_tdata;

    // Local copy of the engine state.
    seq_phase_t         seq_phase;
    logic [4:0]         tx_ptr;
    logic [4:0]         rx_ptr;
    logic [7:0]         tx_mem [TX_DEPTH_DEF];
    logic [7:0]         rx_mem [RX_DEPTH_DEF];
    logic               frame_seen;
    logic               byte_seen;
    logic [ADDR7_W-1:0] own_addr;

    result_t engine_results_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_left = 0;
    int items_sent = 0;
    int error_count = 0;
    int cycle_count = 0;

    i2c_slave_byte_engine_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("i2c_slave_byte_engine_top_tb: errors");
            $finish;
        end
    end

    // Applies one event to the local state and returns the result it causes.
    function automatic result_t engine_response(input item_t it);
        result_t r;
        r = '0;
        r.listening = (seq_phase != SEQ_IDLE);
        case (it.mode)
            MODE_START: begin
                seq_phase = SEQ_ADDR;
                r.listening = 1'b1;
            end
            MODE_OVERFLOW: begin
                case (seq_phase)
                    SEQ_IDLE: ;
                    SEQ_ADDR: begin
                        if (it.shifted_byte[7:1] == own_addr) begin
                            if (it.shifted_byte[0]) begin
                                seq_phase = SEQ_TX_LOAD;
                                tx_ptr = '0;
                            end else begin
                                seq_phase = SEQ_RX_ACK;
                                rx_ptr = '0;
                            end
                            r.sda_drive = 1'b1;
                            r.shift_one_bit = 1'b1;
                        end else begin
                            seq_phase = SEQ_IDLE;
                            r.listening = 1'b0;
                        end
                    end
                    SEQ_TX_LOAD, SEQ_TX_ACK: begin
                        // Any nonzero ack bit is a NACK; a used-up store also ends the read.
                        if ((seq_phase == SEQ_TX_ACK && it.shifted_byte != 8'd0) ||
                            tx_ptr >= TX_DEPTH_DEF) begin
                            seq_phase = SEQ_IDLE;
                            r.listening = 1'b0;
                        end else begin
                            r.sda_drive = 1'b1;
                            r.load_byte = tx_mem[tx_ptr];
                            tx_ptr++;
                            seq_phase = SEQ_TX_SHIFT;
                        end
                    end
                    SEQ_TX_SHIFT: begin
                        seq_phase = SEQ_TX_ACK;
                        r.shift_one_bit = 1'b1;
                    end
                    SEQ_RX_ACK: begin
                        seq_phase = SEQ_RX_DATA;
                    end
                    SEQ_RX_DATA: begin
                        // Bytes past the end of the receive store are acked and dropped.
                        if (rx_ptr < RX_DEPTH_DEF) begin
                            rx_mem[rx_ptr] = it.shifted_byte;
                            rx_ptr++;
                            if (rx_ptr == 5'd1) frame_seen = 1'b1;
                            byte_seen = 1'b1;
                        end
                        seq_phase = SEQ_RX_ACK;
                        r.sda_drive = 1'b1;
                        r.shift_one_bit = 1'b1;
                    end
                    default: begin
                        seq_phase = SEQ_IDLE;
                        r.listening = 1'b0;
                    end
                endcase
            end
            MODE_TX_WRITE: tx_mem[it.host_index] = it.host_value;
            MODE_RX_READ:  r.read_data = rx_mem[it.host_index];
            MODE_CLEAR: begin
                frame_seen = 1'b0;
                byte_seen = 1'b0;
            end
            default: ;
        endcase
        r.new_frame = frame_seen;
        r.new_byte = byte_seen;
        r.received_count = rx_ptr;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (engine_results_due.size() == 0) begin
                $display("%0t unexpected result transfer: expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = engine_results_due.pop_front();
                compare_field("sda_drive", int'(want.sda_drive), int'(m_tdata[0]));
                compare_field("load_byte", int'(want.load_byte), int'(m_tdata[8:1]));
                compare_field("shift_one_bit", int'(want.shift_one_bit), int'(m_tdata[9]));
                compare_field("listening", int'(want.listening), int'(m_tdata[10]));
                compare_field("read_data", int'(want.read_data), int'(m_tdata[18:11]));
                compare_field("new_frame", int'(want.new_frame), int'(m_tdata[19]));
                compare_field("new_byte", int'(want.new_byte), int'(m_tdata[20]));
                compare_field("received_count", int'(want.received_count),
                              int'(m_tdata[25:21]));
            end
        end
    end

    // All driving tasks are left just after a falling edge and, but for reset_dut at time zero, entered just after one.
    task automatic send_item(input logic [2:0] mode, input logic [7:0] sb,
                             input logic [3:0] idx, input logic [7:0] val);
        item_t it;
        it.mode = mode;
        it.shifted_byte = sb;
        it.host_index = idx;
        it.host_value = val;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, val, idx, sb};
        s_tuser <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        engine_results_due.push_back(engine_response(it));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_overflow(input logic [7:0] sb);
        send_item(MODE_OVERFLOW, sb, 4'($urandom()), 8'($urandom()));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (engine_results_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_own_address(input logic [ADDR7_W-1:0] addr);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        own_addr = addr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic reset_dut();
        seq_phase = SEQ_IDLE;
        tx_ptr = '0;
        rx_ptr = '0;
        frame_seen = 1'b0;
        byte_seen = 1'b0;
        own_addr = '0;
        foreach (tx_mem[i]) tx_mem[i] = '0;
        foreach (rx_mem[i]) rx_mem[i] = '0;
        aresetn <= 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
    endtask

    task automatic test_directed_events();
        send_idle_pct = 25;
        recv_idle_pct = 25;
        // Overflow before any start condition is ignored; undefined modes do nothing.
        send_overflow(8'hff);
        send_item(MODE_UNDEF_5, 8'hff, 4'hf, 8'hff);
        send_item(MODE_UNDEF_7, 8'h00, 4'h0, 8'h00);
        send_item(MODE_TX_WRITE, 8'h00, 4'h0, 8'hff);
        send_item(MODE_TX_WRITE, 8'hff, 4'h1, 8'ha5);
        write_own_address(7'h7f);
        // Read transfer: two bytes, the second one NACKed with a nonzero bit pattern.
        send_item(MODE_START, 8'h00, 4'h0, 8'h00);
        send_overflow(8'hff);
        send_overflow(8'h00);
        send_overflow(8'h00);
        send_overflow(8'h00);
        send_overflow(8'h00);
        send_overflow(8'h80);
        // Write transfer of two bytes, then host reads and a flag clear.
        send_item(MODE_START, 8'h00, 4'h0, 8'h00);
        send_overflow(8'hfe);
        send_overflow(8'h00);
        send_overflow(8'h00);
        send_overflow(8'h00);
        send_overflow(8'hff);
        send_item(MODE_RX_READ, 8'h00, 4'h0, 8'h00);
        send_item(MODE_RX_READ, 8'h00, 4'h1, 8'h00);
        send_item(MODE_CLEAR, 8'h00, 4'h0, 8'h00);
        // A new start keeps the positions; a foreign address drops back to idle.
        send_item(MODE_START, 8'h00, 4'h0, 8'h00);
        send_overflow(8'h00);
    endtask

    task automatic send_random_sequence();
        int pick;
        int n;
        logic [6:0] other;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // Write frame, sometimes longer than the receive store.
            send_item(MODE_START, 8'($urandom()), 4'($urandom()), 8'($urandom()));
            send_overflow({own_addr, 1'b0});
            n = $urandom_range(0, 20);
            for (int k = 0; k < n; k++) begin
                send_overflow(8'($urandom()));
                send_overflow(8'($urandom()));
            end
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++)
                send_item(MODE_RX_READ, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        end else if (pick < 65) begin
            // Read frame ending in a NACK, or running past the transmit store.
            send_item(MODE_START, 8'($urandom()), 4'($urandom()), 8'($urandom()));
            send_overflow({own_addr, 1'b1});
            send_overflow(8'($urandom()));
            n = $urandom_range(1, 18);
            for (int k = 0; k < n; k++) begin
                send_overflow(8'($urandom()));
                send_overflow((k == n - 1) ? 8'($urandom_range(1, 255)) : 8'h00);
                if (k != n - 1) send_overflow(8'($urandom()));
            end
        end else if (pick < 75) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                send_item(MODE_TX_WRITE, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        end else if (pick < 82) begin
            send_item(MODE_RX_READ, 8'($urandom()), 4'($urandom()), 8'($urandom()));
            send_item(MODE_CLEAR, 8'($urandom()), 4'($urandom()), 8'($urandom()));
        end else if (pick < 90) begin
            other = own_addr ^ 7'($urandom_range(1, 127));
            send_item(MODE_START, 8'($urandom()), 4'($urandom()), 8'($urandom()));
            send_overflow({other, 1'($urandom())});
            send_overflow(8'($urandom()));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                send_item(3'($urandom_range(0, 7)), 8'($urandom()), 4'($urandom()),
                          8'($urandom()));
        end
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_items, input logic [ADDR7_W-1:0] addr);
        int first;
        write_own_address(addr);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        first = items_sent;
        while (items_sent - first < n_items) send_random_sequence();
    endtask

    task automatic test_output_stall();
        write_own_address(7'($urandom()));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        rx_hold_left = 300;
        @(negedge aclk);
        // The sender keeps offering while the receiver holds off, so the block backs up.
        for (int k = 0; k < 12; k++) send_random_sequence();
    endtask

    initial begin
        reset_dut();
        test_directed_events();
        test_random_traffic(25, 83, 200, 7'h00);
        test_random_traffic(83, 25, 200, 7'($urandom()));
        test_random_traffic(0, 0, 200, 7'h7f);
        test_output_stall();
        drain_results();
        repeat (8) @(negedge aclk);
        if (error_count == 0 && engine_results_due.size() == 0) begin
            $display("i2c_slave_byte_engine_top_tb: clean");
        end else begin
            $display("i2c_slave_byte_engine_top_tb: errors");
        end
        $finish;
    end

endmodule
